### rtl/oacl_pkg.sv
// Shared constants of the object access-control table: request codes, status codes
// and default table sizes. Has no dependencies.
`timescale 1ns / 1ps
package oacl_pkg;

  localparam int OBJECT_SLOTS_DEF       = 32;
  localparam int ENTRIES_PER_OBJECT_DEF = 32;

  localparam int ID_W     = 16;
  localparam int RIGHTS_W = 3;
  localparam int STATUS_W = 4;
  localparam int ACTION_W = 2;

  localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GRANT  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REVOKE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_CREATED    = 4'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 4'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_NO_OBJECT  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_CHANGED    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_GIVEN      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_ACL_FULL   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_REVOKED    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NO_DOMAIN  = 4'd8;

endpackage

### rtl/oacl_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the object table and the entry table; no dependencies.
`timescale 1ns / 1ps
module oacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/object_acl_table_top.sv
// Top level of the object access-control table: request sequencer around two RAMs.
// Depends on oacl_pkg and oacl_ram.
`timescale 1ns / 1ps
// After reset the block builds its free-row map and holds busy high. A transaction
// is taken when start is high and busy is low; its status appears on out_status
// with out_strobe, which is high for a single cycle, and the receiver cannot stall
// it. Each object slot points to a physical row of the entry RAM, so deleting an
// object shifts only the object table. A request other than create searches the
// object table; grant and revoke then search the object's entry list. Delete and
// revoke shift the later slots or entries down by one, reading one slot or entry
// at a time through the single read port of each RAM.
module object_acl_table_top
  import oacl_pkg::*;
#(
  parameter int OBJECT_SLOTS       = OBJECT_SLOTS_DEF,
  parameter int ENTRIES_PER_OBJECT = ENTRIES_PER_OBJECT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [ID_W-1:0]     in_object_id,
  input  logic [ID_W-1:0]     in_domain_id,
  input  logic [RIGHTS_W-1:0] in_rights,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status
);

  localparam int OW    = $clog2(OBJECT_SLOTS);
  localparam int OCW   = $clog2(OBJECT_SLOTS + 1);
  localparam int EW    = $clog2(ENTRIES_PER_OBJECT);
  localparam int ECW   = $clog2(ENTRIES_PER_OBJECT + 1);
  localparam int CNTW  = (OCW > ECW) ? OCW : ECW;
  localparam int EDEP  = OBJECT_SLOTS * ENTRIES_PER_OBJECT;
  localparam int AW    = $clog2(EDEP);
  localparam int OBJ_W = ID_W + ECW + OW;
  localparam int ENT_W = ID_W + RIGHTS_W;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CRT  = 4'd2;
  localparam logic [3:0] S_OSR  = 4'd3;
  localparam logic [3:0] S_DEL  = 4'd4;
  localparam logic [3:0] S_DELE = 4'd5;
  localparam logic [3:0] S_ESR  = 4'd6;
  localparam logic [3:0] S_REV  = 4'd7;
  localparam logic [3:0] S_REVE = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [CNTW-1:0]     pidx_r, pidx_nxt;
  logic                pv_r, pv_nxt;
  logic [OCW-1:0]      total_r, total_nxt;
  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [ID_W-1:0]     dom_r, dom_nxt;
  logic [RIGHTS_W-1:0] rts_r, rts_nxt;
  logic [OW-1:0]       slot_r, slot_nxt;
  logic [OW-1:0]       row_r, row_nxt;
  logic [ECW-1:0]      etot_r, etot_nxt;
  logic [ID_W-1:0]     objid_r, objid_nxt;
  logic                strobe_r, strobe_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic              obj_we;
  logic [OW-1:0]     obj_wa, obj_ra;
  logic [OBJ_W-1:0]  obj_wd, obj_q;
  logic              ent_we;
  logic [AW-1:0]     ent_wa, ent_ra;
  logic [ENT_W-1:0]  ent_wd, ent_q;

  logic [ID_W-1:0]   q_id;
  logic [ECW-1:0]    q_tot;
  logic [OW-1:0]     q_row;
  logic [CNTW-1:0]   limit;
  logic              issue;

  assign q_id  = obj_q[OBJ_W-1 -: ID_W];
  assign q_tot = obj_q[OW +: ECW];
  assign q_row = obj_q[OW-1:0];

  function automatic logic [AW-1:0] ent_addr(input logic [OW-1:0] row,
                                             input logic [EW-1:0] idx);
    ent_addr = AW'(row) * AW'(ENTRIES_PER_OBJECT) + AW'(idx);
  endfunction

  oacl_ram #(.WIDTH(OBJ_W), .DEPTH(OBJECT_SLOTS)) u_obj_ram (
    .clk(clk), .we(obj_we), .waddr(obj_wa), .wdata(obj_wd),
    .raddr(obj_ra), .rdata(obj_q)
  );

  oacl_ram #(.WIDTH(ENT_W), .DEPTH(EDEP)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
    .raddr(ent_ra), .rdata(ent_q)
  );

  always_comb begin
    case (state_r)
      S_IDLE:  obj_ra = total_r[OW-1:0];
      default: obj_ra = cnt_r[OW-1:0];
    endcase
    ent_ra = ent_addr(row_r, cnt_r[EW-1:0]);
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pidx_nxt   = pidx_r;
    pv_nxt     = pv_r;
    total_nxt  = total_r;
    act_nxt    = act_r;
    id_nxt     = id_r;
    dom_nxt    = dom_r;
    rts_nxt    = rts_r;
    slot_nxt   = slot_r;
    row_nxt    = row_r;
    etot_nxt   = etot_r;
    objid_nxt  = objid_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    obj_we     = 1'b0;
    obj_wa     = '0;
    obj_wd     = '0;
    ent_we     = 1'b0;
    ent_wa     = '0;
    ent_wd     = '0;

    if (state_r == S_OSR || state_r == S_DEL) begin
      limit = CNTW'(total_r);
    end else begin
      limit = CNTW'(etot_r);
    end
    issue = (cnt_r < limit);
    if (state_r == S_OSR || state_r == S_DEL || state_r == S_ESR || state_r == S_REV) begin
      pv_nxt   = issue;
      pidx_nxt = cnt_r;
      if (issue) begin
        cnt_nxt = cnt_r + CNTW'(1);
      end
    end

    case (state_r)
      S_INIT: begin
        obj_we  = 1'b1;
        obj_wa  = cnt_r[OW-1:0];
        obj_wd  = {ID_W'(0), ECW'(0), cnt_r[OW-1:0]};
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(OBJECT_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          act_nxt = in_action;
          id_nxt  = in_object_id;
          dom_nxt = in_domain_id;
          rts_nxt = in_rights;
          cnt_nxt = '0;
          pv_nxt  = 1'b0;
          if (in_action == ACT_CREATE) begin
            if (total_r == OCW'(OBJECT_SLOTS)) begin
              strobe_nxt = 1'b1;
              status_nxt = ST_TABLE_FULL;
            end else begin
              state_nxt = S_CRT;
            end
          end else begin
            state_nxt = S_OSR;
          end
        end
      end
      S_CRT: begin
        obj_we     = 1'b1;
        obj_wa     = total_r[OW-1:0];
        obj_wd     = {id_r, ECW'(0), q_row};
        total_nxt  = total_r + OCW'(1);
        strobe_nxt = 1'b1;
        status_nxt = ST_CREATED;
        state_nxt  = S_IDLE;
      end
      S_OSR: begin
        if (pv_r && q_id == id_r) begin
          slot_nxt  = pidx_r[OW-1:0];
          row_nxt   = q_row;
          etot_nxt  = q_tot;
          objid_nxt = q_id;
          pv_nxt    = 1'b0;
          if (act_r == ACT_DELETE) begin
            cnt_nxt   = pidx_r + CNTW'(1);
            state_nxt = S_DEL;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_ESR;
          end
        end else if (!pv_r && !issue) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_NO_OBJECT;
          state_nxt  = S_IDLE;
        end
      end
      S_DEL: begin
        if (pv_r) begin
          obj_we = 1'b1;
          obj_wa = OW'(pidx_r - CNTW'(1));
          obj_wd = obj_q;
        end else if (!issue) begin
          state_nxt = S_DELE;
        end
      end
      S_DELE: begin
        obj_we     = 1'b1;
        obj_wa     = OW'(total_r - OCW'(1));
        obj_wd     = {id_r, ECW'(0), row_r};
        total_nxt  = total_r - OCW'(1);
        strobe_nxt = 1'b1;
        status_nxt = ST_DELETED;
        state_nxt  = S_IDLE;
      end
      S_ESR: begin
        if (pv_r && ent_q[ENT_W-1 -: ID_W] == dom_r) begin
          pv_nxt = 1'b0;
          if (act_r == ACT_GRANT) begin
            ent_we     = 1'b1;
            ent_wa     = ent_addr(row_r, pidx_r[EW-1:0]);
            ent_wd     = {dom_r, rts_r};
            strobe_nxt = 1'b1;
            status_nxt = ST_CHANGED;
            state_nxt  = S_IDLE;
          end else begin
            cnt_nxt   = pidx_r + CNTW'(1);
            state_nxt = S_REV;
          end
        end else if (!pv_r && !issue) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
          if (act_r == ACT_GRANT) begin
            if (etot_r == ECW'(ENTRIES_PER_OBJECT)) begin
              status_nxt = ST_ACL_FULL;
            end else begin
              ent_we     = 1'b1;
              ent_wa     = ent_addr(row_r, etot_r[EW-1:0]);
              ent_wd     = {dom_r, rts_r};
              obj_we     = 1'b1;
              obj_wa     = slot_r;
              obj_wd     = {objid_r, etot_r + ECW'(1), row_r};
              status_nxt = ST_GIVEN;
            end
          end else begin
            status_nxt = ST_NO_DOMAIN;
          end
        end
      end
      S_REV: begin
        if (pv_r) begin
          ent_we = 1'b1;
          ent_wa = ent_addr(row_r, EW'(pidx_r - CNTW'(1)));
          ent_wd = ent_q;
        end else if (!issue) begin
          state_nxt = S_REVE;
        end
      end
      S_REVE: begin
        obj_we     = 1'b1;
        obj_wa     = slot_r;
        obj_wd     = {objid_r, etot_r - ECW'(1), row_r};
        strobe_nxt = 1'b1;
        status_nxt = ST_REVOKED;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      cnt_r    <= '0;
      pv_r     <= 1'b0;
      total_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pv_r     <= pv_nxt;
      total_r  <= total_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r   <= pidx_nxt;
    act_r    <= act_nxt;
    id_r     <= id_nxt;
    dom_r    <= dom_nxt;
    rts_r    <= rts_nxt;
    slot_r   <= slot_nxt;
    row_r    <= row_nxt;
    etot_r   <= etot_nxt;
    objid_r  <= objid_nxt;
    status_r <= status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_status = status_r;

endmodule
